/* src/vsfr_pkg.sv */
// ----------------------------------------------------------------------------
// vsfr_pkg: shared definitions for the video SPI frame receiver
// Packet geometry, field widths, result codes and the control word that
// passes from the frame tracker to the pixel statistics unit.
// ----------------------------------------------------------------------------
package vsfr_pkg;

  // Packet geometry
  localparam int PACKET_BYTES      = 164;
  localparam int PACKETS_PER_FRAME = 60;
  localparam int HEADER_BYTES      = 4;
  localparam int PIXELS_PER_PACKET = (PACKET_BYTES - HEADER_BYTES) / 2;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 7;
  localparam int PIX_W   = 16;
  localparam int SUM_W   = 29;
  localparam int REJ_W   = 10;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [REJ_W-1:0] RESYNC_LIMIT_RESET = REJ_W'(750);
  localparam logic [REJ_W-1:0] REJECT_MAX         = '1;
  localparam logic [PIX_W-1:0] PIX_MAX            = '1;
  localparam logic [SUM_W-1:0] SUM_MAX            = '1;

  // Register index of resync_limit (byte address 4 * index)
  localparam logic [ADDR_W-3:0] REG_RESYNC_LIMIT = '0;

  // Result kinds
  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_REJECT = 1'b1
  } result_kind_t;

  // Per-word decode handed from the frame tracker to the statistics unit
  typedef struct packed {
    logic             reject;
    logic             resync;
    logic             hold_hi;
    logic             pixel;
    logic             last;
    logic             stats_clear;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } vsfr_ctl_t;

endpackage

/* src/vsfr_frame_track.sv */
// ----------------------------------------------------------------------------
// vsfr_frame_track: packet position and frame sequencing
// Tracks byte position, expected packet index and reject count, checks the
// packet index byte and decodes what the current word means.
// ----------------------------------------------------------------------------
module vsfr_frame_track
  import vsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [REJ_W-1:0]  resync_limit,
  output vsfr_ctl_t         ctl
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [ROW_W-1:0] expected_packet, expected_packet_next;
  logic             packet_accepted, packet_accepted_next;
  logic [REJ_W-1:0] reject_count, reject_count_next;

  logic [POS_W-1:0] off;
  logic             pkt_end;
  logic             frame_end;

  always_comb begin
    off                  = byte_position - POS_W'(HEADER_BYTES);
    ctl                  = '0;
    ctl.row              = expected_packet;
    ctl.col              = COL_W'(off >> 1);
    byte_position_next   = byte_position + POS_W'(1);
    expected_packet_next = expected_packet;
    packet_accepted_next = packet_accepted;
    reject_count_next    = reject_count;
    frame_end            = 1'b0;

    if (byte_position == POS_W'(1)) begin
      if (data_byte == BYTE_W'(expected_packet)) begin
        packet_accepted_next = 1'b1;
      end else begin
        // Drop the packet and restart the frame
        packet_accepted_next = 1'b0;
        expected_packet_next = '0;
        ctl.reject           = 1'b1;
        ctl.stats_clear      = 1'b1;
        if (reject_count != REJECT_MAX) begin
          reject_count_next = reject_count + REJ_W'(1);
          ctl.resync        = (reject_count_next == resync_limit);
        end
      end
    end else if (byte_position >= POS_W'(HEADER_BYTES) && packet_accepted) begin
      if (!off[0]) begin
        ctl.hold_hi = 1'b1;
      end else if (ctl.col < COL_W'(PIXELS_PER_PACKET)) begin
        ctl.pixel = 1'b1;
        ctl.last  = (expected_packet == ROW_W'(PACKETS_PER_FRAME - 1)) &&
                    (ctl.col == COL_W'(PIXELS_PER_PACKET - 1));
      end
    end

    pkt_end = (byte_position >= POS_W'(PACKET_BYTES - 1));
    if (pkt_end) begin
      if (packet_accepted_next) begin
        if (expected_packet == ROW_W'(PACKETS_PER_FRAME - 1)) begin
          frame_end            = 1'b1;
          expected_packet_next = '0;
        end else begin
          expected_packet_next = expected_packet + ROW_W'(1);
        end
      end
      packet_accepted_next = 1'b0;
      byte_position_next   = '0;
    end

    if (frame_end) begin
      ctl.stats_clear   = 1'b1;
      reject_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      expected_packet <= '0;
      packet_accepted <= 1'b0;
      reject_count    <= '0;
    end else if (adv) begin
      byte_position   <= byte_position_next;
      expected_packet <= expected_packet_next;
      packet_accepted <= packet_accepted_next;
      reject_count    <= reject_count_next;
    end
  end

endmodule

/* src/vsfr_pixel_stats.sv */
// ----------------------------------------------------------------------------
// vsfr_pixel_stats: pixel assembly and running frame statistics
// Joins the held high byte with the low byte and keeps min, max and a
// saturating sum over the frame.
// ----------------------------------------------------------------------------
module vsfr_pixel_stats
  import vsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [BYTE_W-1:0] data_byte,
  input  vsfr_ctl_t         ctl,
  output logic [PIX_W-1:0]  pix_value,
  output logic [PIX_W-1:0]  min_upd,
  output logic [PIX_W-1:0]  max_upd,
  output logic [SUM_W-1:0]  sum_upd
);

  logic [BYTE_W-1:0] held_high_byte;
  logic [PIX_W-1:0]  running_min;
  logic [PIX_W-1:0]  running_max;
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W:0]    sum_wide;

  always_comb begin
    pix_value = {held_high_byte, data_byte};
    sum_wide  = {1'b0, running_sum} + (SUM_W + 1)'(pix_value);
    min_upd   = running_min;
    max_upd   = running_max;
    sum_upd   = running_sum;
    if (ctl.pixel) begin
      if (pix_value < running_min) min_upd = pix_value;
      if (pix_value > running_max) max_upd = pix_value;
      sum_upd = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_byte <= '0;
      running_min    <= PIX_MAX;
      running_max    <= '0;
      running_sum    <= '0;
    end else if (adv) begin
      if (ctl.hold_hi) held_high_byte <= data_byte;
      if (ctl.stats_clear) begin
        running_min <= PIX_MAX;
        running_max <= '0;
        running_sum <= '0;
      end else begin
        running_min <= min_upd;
        running_max <= max_upd;
        running_sum <= sum_upd;
      end
    end
  end

endmodule

/* src/video_spi_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// video_spi_frame_receiver_core: thermal camera video SPI frame receiver
// Checks packet indices, unpacks 16-bit pixels and reports frame statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one SPI byte per word on spi_byte, qualified by in_valid,
//   held back by in_stall. The stream must be packet aligned after reset.
//   Output channel: zero or one result word per input word, qualified by
//   out_valid, held back by out_stall. result_kind tells a pixel from a
//   rejected packet; frame_last marks the final pixel of a frame and carries
//   the frame's min, max and sum; resync_request flags the reject at which
//   the reject count meets resync_limit.
//   Config: APB write of resync_limit at byte address 0, reads return it.
// Timing:
//   A word is captured in the input register; as it advances it is decoded
//   and folded into the statistics, and its result lands in the output
//   register at that same advance. One word per cycle is sustained while
//   out_stall is low, as position and statistics update with each advance.
// Reset and backpressure:
//   Synchronous reset clears both registers, the packet state, statistics
//   and reject count, and sets resync_limit to 750. While out_stall holds a
//   waiting result, the captured word holds and in_stall rises.
// ----------------------------------------------------------------------------
module video_spi_frame_receiver_core
  import vsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] spi_byte,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              result_kind,
  output logic [PIX_W-1:0]  pixel_value,
  output logic [ROW_W-1:0]  pixel_row,
  output logic [COL_W-1:0]  pixel_col,
  output logic              frame_last,
  output logic [PIX_W-1:0]  frame_min,
  output logic [PIX_W-1:0]  frame_max,
  output logic [SUM_W-1:0]  frame_sum,
  output logic              resync_request,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [REJ_W-1:0]  resync_limit;
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              adv;
  logic              has_result;
  vsfr_ctl_t         ctl;
  logic [PIX_W-1:0]  pix_value;
  logic [PIX_W-1:0]  min_upd;
  logic [PIX_W-1:0]  max_upd;
  logic [SUM_W-1:0]  sum_upd;

  // Configuration port: decode on the word address, ignore the byte lanes
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_RESYNC_LIMIT) ? DATA_W'(resync_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      resync_limit <= RESYNC_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_RESYNC_LIMIT) begin
      resync_limit <= pwdata[REJ_W-1:0];
    end
  end

  // Advance the captured word when the output register is free or emptying
  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte <= spi_byte;
  end

  vsfr_frame_track u_track (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .data_byte    (in_byte),
    .resync_limit (resync_limit),
    .ctl          (ctl)
  );

  vsfr_pixel_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .data_byte (in_byte),
    .ctl       (ctl),
    .pix_value (pix_value),
    .min_upd   (min_upd),
    .max_upd   (max_upd),
    .sum_upd   (sum_upd)
  );

  assign has_result = ctl.reject || ctl.pixel;

  // Output register: load on a result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      result_kind    <= ctl.reject ? KIND_REJECT : KIND_PIXEL;
      resync_request <= ctl.reject && ctl.resync;
      pixel_value    <= ctl.pixel ? pix_value : '0;
      pixel_row      <= ctl.pixel ? ctl.row : '0;
      pixel_col      <= ctl.pixel ? ctl.col : '0;
      frame_last     <= ctl.pixel && ctl.last;
      frame_min      <= (ctl.pixel && ctl.last) ? min_upd : '0;
      frame_max      <= (ctl.pixel && ctl.last) ? max_upd : '0;
      frame_sum      <= (ctl.pixel && ctl.last) ? sum_upd : '0;
    end
  end

endmodule

/* src/vsfr_checker.sv */
// ----------------------------------------------------------------------------
// vsfr_checker: port-level checks for the frame receiver
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module vsfr_checker
  import vsfr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             result_kind,
  input logic [PIX_W-1:0] pixel_value,
  input logic [ROW_W-1:0] pixel_row,
  input logic [COL_W-1:0] pixel_col,
  input logic             frame_last,
  input logic [SUM_W-1:0] frame_sum,
  input logic             resync_request
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(result_kind))
    else $error("stalled result word changed");

  a_resync_on_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && resync_request |-> result_kind == KIND_REJECT && !frame_last)
    else $error("resync request outside a reject");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      pixel_row == ROW_W'(PACKETS_PER_FRAME - 1) &&
      pixel_col == COL_W'(PIXELS_PER_PACKET - 1))
    else $error("frame end flagged away from the final pixel");

  a_sum_only_at_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> frame_sum == '0)
    else $error("frame sum shown before frame end");

endmodule

bind video_spi_frame_receiver_core vsfr_checker u_vsfr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .result_kind    (result_kind),
  .pixel_value    (pixel_value),
  .pixel_row      (pixel_row),
  .pixel_col      (pixel_col),
  .frame_last     (frame_last),
  .frame_sum      (frame_sum),
  .resync_request (resync_request)
);
